@@ hw/rtl/esbk_pkg.sv @@
// Shared types and constants for the exchange sort by key block.
`timescale 1ns / 1ps

package esbk_pkg;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned TagW   = 8;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // register index, taken from paddr[2]
  localparam logic RegDescending = 1'b0;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

endpackage

@@ hw/rtl/esbk_mem.sv @@
// Record store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module esbk_mem import esbk_pkg::*; #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem_q [Depth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/esbk_regs.sv @@
// APB-style configuration register: sort direction.
`timescale 1ns / 1ps

module esbk_regs import esbk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic              descending_o
);

  logic descending_q, descending_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    descending_d = descending_q;
    if (wr_en && paddr[2] == RegDescending) begin
      descending_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else begin
      descending_q <= descending_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDescending) begin
      prdata = {{(PdataW-1){1'b0}}, descending_q};
    end
  end

  assign descending_o = descending_q;

endmodule

@@ hw/rtl/esbk_sort.sv @@
// Load, exchange sort and emit sequencer around the record store.
`timescale 1ns / 1ps

module esbk_sort import esbk_pkg::*; #(
  parameter int unsigned Capacity = 32,
  parameter int unsigned AddrW    = 5,
  parameter int unsigned CntW     = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             descending_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KeyW-1:0]  quantity_i,
  input  logic [TagW-1:0]  record_tag_i,
  input  logic             last_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KeyW-1:0]  sorted_quantity_o,
  output logic [TagW-1:0]  sorted_tag_o,
  output logic             last_of_run_o,
  output logic             overflow_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output rec_t             mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  rec_t             mem_rdata_i
);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SHead  = 3'd1;
  localparam logic [2:0] SPrime = 3'd2;
  localparam logic [2:0] SCmp   = 3'd3;
  localparam logic [2:0] SWb    = 3'd4;
  localparam logic [2:0] SErd   = 3'd5;
  localparam logic [2:0] SEout  = 3'd6;
  localparam logic [2:0] SEhold = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic            dropped_q, dropped_d;
  logic            ovf_q, ovf_d;
  logic            desc_q, desc_d;
  logic [AddrW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  rec_t            cur_q, cur_d;
  rec_t            out_q, out_d;
  logic            out_last_q, out_last_d;
  logic            out_valid_q, out_valid_d;
  logic            swap;

  assign swap = desc_q ? (cur_q.key < mem_rdata_i.key) : (cur_q.key > mem_rdata_i.key);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    dropped_d   = dropped_q;
    ovf_d       = ovf_q;
    desc_d      = desc_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = i_q;
    mem_wdata_o = cur_q;
    mem_raddr_o = j_q;

    unique case (state_q)
      SLoad: begin
        if (in_valid_i) begin
          if (count_q < CntW'(Capacity)) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AddrW-1:0];
            mem_wdata_o = '{key: quantity_i, tag: record_tag_i};
            count_d     = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_item_i) begin
            n_d       = count_d;
            ovf_d     = dropped_d;
            desc_d    = descending_i;
            count_d   = '0;
            dropped_d = 1'b0;
            i_d       = '0;
            j_d       = AddrW'(1);
            k_d       = '0;
            state_d   = (n_d == CntW'(1)) ? SErd : SHead;
          end
        end
      end
      SHead: begin
        mem_raddr_o = i_q;
        state_d     = SPrime;
      end
      SPrime: begin
        cur_d       = mem_rdata_i;
        mem_raddr_o = j_q;
        state_d     = SCmp;
      end
      SCmp: begin
        if (swap) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = j_q;
          mem_wdata_o = cur_q;
          cur_d       = mem_rdata_i;
        end
        if (CntW'(j_q) == n_q - CntW'(1)) begin
          state_d = SWb;
        end else begin
          j_d         = j_q + AddrW'(1);
          mem_raddr_o = j_q + AddrW'(1);
        end
      end
      SWb: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_q;
        mem_wdata_o = cur_q;
        if (CntW'(i_q) + CntW'(2) < n_q) begin
          i_d         = i_q + AddrW'(1);
          j_d         = i_q + AddrW'(2);
          mem_raddr_o = i_q + AddrW'(1);
          state_d     = SPrime;
        end else begin
          k_d     = '0;
          state_d = SErd;
        end
      end
      SErd: begin
        mem_raddr_o = k_q;
        state_d     = SEout;
      end
      SEout: begin
        out_d       = mem_rdata_i;
        out_last_d  = (CntW'(k_q) == n_q - CntW'(1));
        out_valid_d = 1'b1;
        state_d     = SEhold;
      end
      SEhold: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = SLoad;
          end else begin
            k_d         = k_q + AddrW'(1);
            mem_raddr_o = k_q + AddrW'(1);
            state_d     = SEout;
          end
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SLoad;
      count_q     <= '0;
      n_q         <= '0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      desc_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      dropped_q   <= dropped_d;
      ovf_q       <= ovf_d;
      desc_q      <= desc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o        = (state_q == SLoad);
  assign out_valid_o       = out_valid_q;
  assign sorted_quantity_o = out_q.key;
  assign sorted_tag_o      = out_q.tag;
  assign last_of_run_o     = out_last_q;
  assign overflow_o        = ovf_q;

endmodule

@@ hw/rtl/exchange_sort_by_key.sv @@
// Top level of the exchange sort by key block.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   quantity_i, record_tag_i, last_item_i
//   output    out        out_valid_o / out_ready_i sorted_quantity_o, sorted_tag_o,
//                                                  last_of_run_o, overflow_o
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata (reg 0: descending)
//
// A record that does not close the set is stored, or dropped once the store is full.
// Closing with n > 1 records starts the sort, one store read per cycle; one record
// skips it. Emission then reads each record and holds it until out_ready_i takes it.
// Input is not accepted during sort and emission; reset leaves the store contents
// undefined and needs no clearing pass.
`timescale 1ns / 1ps

module exchange_sort_by_key import esbk_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KeyW-1:0]   quantity_i,
  input  logic [TagW-1:0]   record_tag_i,
  input  logic              last_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KeyW-1:0]   sorted_quantity_o,
  output logic [TagW-1:0]   sorted_tag_o,
  output logic              last_of_run_o,
  output logic              overflow_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic             descending;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  rec_t             mem_wdata;
  rec_t             mem_rdata;

  esbk_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .descending_o (descending)
  );

  esbk_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  esbk_sort #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_sort (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .descending_i      (descending),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .quantity_i        (quantity_i),
    .record_tag_i      (record_tag_i),
    .last_item_i       (last_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sorted_quantity_o (sorted_quantity_o),
    .sorted_tag_o      (sorted_tag_o),
    .last_of_run_o     (last_of_run_o),
    .overflow_o        (overflow_o),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

endmodule

@@ sim/sort_checker.sv @@
// Checker for exchange_sort_by_key: predicts each sorted set and compares output transfers.
`timescale 1ns / 1ps

module sort_checker import esbk_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [KeyW-1:0]   quantity_i,
  input  logic [TagW-1:0]   record_tag_i,
  input  logic              last_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [KeyW-1:0]   sorted_quantity_i,
  input  logic [TagW-1:0]   sorted_tag_i,
  input  logic              last_of_run_i,
  input  logic              overflow_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [PdataW-1:0] pwdata_i,
  input  logic              pready_i,
  output int                mismatches_o,
  output int                pending_o
);

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            last;
    logic            ovf;
  } sorted_rec_t;

  rec_t          held[CAPACITY];
  int unsigned   held_n = 0;
  logic          lost = 1'b0;
  logic          desc_mode = 1'b0;
  int            errs = 0;
  sorted_rec_t   sorted_due_q[$];

  assign mismatches_o = errs;

  task automatic sort_and_queue();
    rec_t        tmp;
    logic        swap;
    sorted_rec_t r;
    for (int unsigned i = 0; i + 1 < held_n; i++) begin
      for (int unsigned j = i + 1; j < held_n; j++) begin
        swap = desc_mode ? (held[i].key < held[j].key) : (held[i].key > held[j].key);
        if (swap) begin
          tmp     = held[i];
          held[i] = held[j];
          held[j] = tmp;
        end
      end
    end
    for (int unsigned k = 0; k < held_n; k++) begin
      r.key  = held[k].key;
      r.tag  = held[k].tag;
      r.last = (k + 1 == held_n);
      r.ovf  = lost;
      sorted_due_q.push_back(r);
    end
    held_n = 0;
    lost   = 1'b0;
  endtask

  task automatic check_sorted();
    sorted_rec_t e;
    if (sorted_due_q.size() == 0) begin
      $error("unexpected output transfer: sorted_quantity %0d sorted_tag %0d",
             sorted_quantity_i, sorted_tag_i);
      errs++;
    end else begin
      e = sorted_due_q.pop_front();
      if (sorted_quantity_i !== e.key) begin
        $error("sorted_quantity: expected %0d, got %0d", e.key, sorted_quantity_i);
        errs++;
      end
      if (sorted_tag_i !== e.tag) begin
        $error("sorted_tag: expected %0d, got %0d", e.tag, sorted_tag_i);
        errs++;
      end
      if (last_of_run_i !== e.last) begin
        $error("last_of_run: expected %0b, got %0b", e.last, last_of_run_i);
        errs++;
      end
      if (overflow_i !== e.ovf) begin
        $error("overflow: expected %0b, got %0b", e.ovf, overflow_i);
        errs++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_n    = 0;
      lost      = 1'b0;
      desc_mode = 1'b0;
      sorted_due_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == RegDescending) begin
        desc_mode = pwdata_i[0];
      end
      if (out_valid_i && out_ready_i) begin
        check_sorted();
      end
      if (in_valid_i && in_ready_i) begin
        if (held_n < CAPACITY) begin
          held[held_n].key = quantity_i;
          held[held_n].tag = record_tag_i;
          held_n++;
        end else begin
          lost = 1'b1;
        end
        if (last_item_i) begin
          sort_and_queue();
        end
      end
    end
    pending_o <= sorted_due_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for exchange_sort_by_key: clock, reset, stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_top import esbk_pkg::*; ();

  localparam int unsigned Capacity = 32;
  localparam logic [PaddrW-1:0] AddrDescending = {RegDescending, 2'b00};
  localparam logic [PaddrW-1:0] AddrUnused     = {~RegDescending, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KeyW-1:0]   quantity = '0;
  logic [TagW-1:0]   record_tag = '0;
  logic              last_item = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KeyW-1:0]   sorted_quantity;
  logic [TagW-1:0]   sorted_tag;
  logic              last_of_run;
  logic              overflow;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int items_sent = 0;

  exchange_sort_by_key #(.CAPACITY(Capacity)) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .quantity_i        (quantity),
    .record_tag_i      (record_tag),
    .last_item_i       (last_item),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .sorted_quantity_o (sorted_quantity),
    .sorted_tag_o      (sorted_tag),
    .last_of_run_o     (last_of_run),
    .overflow_o        (overflow),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  sort_checker #(.CAPACITY(Capacity)) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .quantity_i        (quantity),
    .record_tag_i      (record_tag),
    .last_item_i       (last_item),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .sorted_quantity_i (sorted_quantity),
    .sorted_tag_i      (sorted_tag),
    .last_of_run_i     (last_of_run),
    .overflow_i        (overflow),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pready_i          (pready),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // receiver: random stalls, plus long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_record(input logic [KeyW-1:0] k, input logic [TagW-1:0] t,
                             input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    quantity   <= k;
    record_tag <= t;
    last_item  <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: pick_key = KeyW'($urandom_range(3));
      1: pick_key = $urandom_range(1) ? '1 : '0;
      default: pick_key = KeyW'($urandom);
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) begin
      send_record(pick_key(), TagW'($urandom_range(255)), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(input logic desc);
    logic [PdataW-1:0] data;
    data    = $urandom;
    data[0] = desc;
    apb_write(AddrDescending, data);
  endtask

  initial begin
    int target;
    int big_n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single record, ties and extremes in both orders, unused register
    send_record('1, 8'hFF, 1'b1);
    send_record(KeyW'(5), 8'h01, 1'b0);
    send_record('0, 8'h02, 1'b0);
    send_record(KeyW'(5), 8'h03, 1'b0);
    send_record('1, 8'h04, 1'b0);
    send_record('0, 8'h80, 1'b1);
    wait_drained();
    apb_write(AddrDescending, 32'h0000_0001);
    send_record(KeyW'(5), 8'hAA, 1'b0);
    send_record('1, 8'h55, 1'b0);
    send_record(KeyW'(5), 8'h10, 1'b0);
    send_record('0, 8'h20, 1'b1);
    wait_drained();
    apb_write(AddrUnused, 32'h0000_0000);
    send_record(KeyW'(1), 8'h00, 1'b0);
    send_record(KeyW'(2), 8'h01, 1'b0);
    send_record(KeyW'(3), 8'h02, 1'b1);
    wait_drained();
    apb_write(AddrDescending, 32'hFFFF_FFFE);
    send_record(KeyW'(3), 8'h00, 1'b0);
    send_record(KeyW'(2), 8'h01, 1'b0);
    send_record(KeyW'(1), 8'h02, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  big_n = Capacity + 1; end
        1: begin idle_pct = 70; stall_pct = 0;  big_n = Capacity;     end
        2: begin idle_pct = 0;  stall_pct = 70; big_n = 0;            end
        default: begin idle_pct = 12; stall_pct = 12; big_n = Capacity + 3; end
      endcase
      write_order(phase[0] == 1'b0);
      // hold the output off so the next set backs up at the input
      if (phase == 0) hold_req = 900;
      target = items_sent + 40;
      if (big_n != 0) send_set(big_n);
      while (items_sent < target) send_set($urandom_range(1, 8));
      wait_drained();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ exchange_sort_by_key.f @@
hw/rtl/esbk_pkg.sv
hw/rtl/esbk_mem.sv
hw/rtl/esbk_regs.sv
hw/rtl/esbk_sort.sv
hw/rtl/exchange_sort_by_key.sv
sim/sort_checker.sv
sim/tb_top.sv
